@@ rtl/core/rtpq_pkg.sv @@
// Shared constants, codes, types and helper functions of the RTP transport packet queue.
// No dependencies; every other file in rtl/core takes names from here by scope.
`timescale 1ns / 1ps
package rtpq_pkg;

    localparam int QUEUE_SLOTS   = 16;
    localparam int PAYLOAD_WORDS = 47;
    localparam int HDR_WORDS     = 3;
    localparam int PKT_WORDS     = HDR_WORDS + PAYLOAD_WORDS;
    localparam int STORE_WORDS   = 2 * QUEUE_SLOTS * PAYLOAD_WORDS;

    localparam int SLOT_W = $clog2(QUEUE_SLOTS);
    localparam int IDX_W  = $clog2(PAYLOAD_WORDS);
    localparam int CNT_W  = $clog2(PKT_WORDS);
    localparam int ADDR_W = $clog2(STORE_WORDS);

    localparam int WORD_W = 32;
    localparam int SEQ_W  = 16;
    localparam int PT_W   = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [PT_W-1:0] PT_RESET = PT_W'(33);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_WORDS - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PKT_WORDS - 1);
    localparam logic [CNT_W-1:0] CNT_HDR0 = CNT_W'(0);
    localparam logic [CNT_W-1:0] CNT_HDR1 = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_HDR2 = CNT_W'(2);
    // a payload read is issued while the packet word just before it goes out
    localparam logic [CNT_W-1:0] RD_FIRST = CNT_W'(HDR_WORDS - 1);
    localparam logic [CNT_W-1:0] RD_LAST  = CNT_W'(HDR_WORDS + PAYLOAD_WORDS - 2);

    // input operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_SEND = 1'b1;

    // result kinds
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SSRC      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PT        = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic             put;         // put word accepted
        logic             send_start;  // send accepted on a non-empty queue
        logic             send_adv;    // load packet word word_cnt into the output
        logic [CNT_W-1:0] word_cnt;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sel_empty;  // queue named by the incoming item is empty
        logic out_free;   // output register can take a result this cycle
    } t_dp_status;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic q,
                                                     input logic [SLOT_W-1:0] slot,
                                                     input logic [IDX_W-1:0] word);
        store_addr = ADDR_W'((int'(q) * QUEUE_SLOTS + int'(slot)) * PAYLOAD_WORDS
                             + int'(word));
    endfunction

endpackage

@@ rtl/core/rtpq_in_if.sv @@
// Input channel of the RTP transport packet queue: valid/ready plus one put or send item.
// Depends on rtpq_pkg for the word width.
`timescale 1ns / 1ps
interface rtpq_in_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic                         stream_sel;
    logic [rtpq_pkg::WORD_W-1:0]  payload_word;

    modport source (output valid, operation, stream_sel, payload_word, input ready);
    modport sink   (input valid, operation, stream_sel, payload_word, output ready);
endinterface

@@ rtl/core/rtpq_out_if.sv @@
// Output channel of the RTP transport packet queue: valid/ready plus one result item.
// Depends on rtpq_pkg for the word width.
`timescale 1ns / 1ps
interface rtpq_out_if;
    logic                         valid;
    logic                         ready;
    logic                         item_kind;
    logic [rtpq_pkg::WORD_W-1:0]  packet_word;
    logic                         last_word;
    logic                         put_status;
    logic                         stream_out;

    modport source (output valid, item_kind, packet_word, last_word, put_status,
                    stream_out, input ready);
    modport sink   (input valid, item_kind, packet_word, last_word, put_status,
                    stream_out, output ready);
endinterface

@@ rtl/core/rtpq_ctrl.sv @@
// Controller of the RTP transport packet queue: input handshake and send sequencer.
// Depends on rtpq_pkg; drives rtpq_dp through t_dp_cmd.
`timescale 1ns / 1ps
module rtpq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_op,
    input  rtpq_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output rtpq_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic {S_IDLE, S_SEND} t_state;

    t_state                     r_state, n_state;
    logic [rtpq_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       in_fire;

    always_comb begin
        o_in_ready        = (r_state == S_IDLE) && i_status.out_free;
        in_fire           = i_in_valid && o_in_ready;
        o_cmd.put         = in_fire && (i_in_op == rtpq_pkg::OP_PUT);
        o_cmd.send_start  = in_fire && (i_in_op == rtpq_pkg::OP_SEND) && !i_status.sel_empty;
        o_cmd.send_adv    = (r_state == S_SEND) && i_status.out_free;
        o_cmd.word_cnt    = r_cnt;

        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.send_start) begin
                    n_state = S_SEND;
                    n_cnt   = '0;
                end
            end
            S_SEND: begin
                if (o_cmd.send_adv) begin
                    if (r_cnt == rtpq_pkg::LAST_CNT) begin
                        n_state = S_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + rtpq_pkg::CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

@@ rtl/core/rtpq_dp.sv @@
// Datapath of the RTP transport packet queue: packet store, queue pointers, config
// registers, sequence counter and output register. Depends on rtpq_pkg.
`timescale 1ns / 1ps
module rtpq_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rtpq_pkg::t_dp_cmd               i_cmd,
    output rtpq_pkg::t_dp_status            o_status,
    input  logic                            i_cfg_we,
    input  logic [rtpq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rtpq_pkg::WORD_W-1:0]     i_cfg_data,
    input  logic                            i_in_stream,
    input  logic [rtpq_pkg::WORD_W-1:0]     i_in_word,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_item_kind,
    output logic [rtpq_pkg::WORD_W-1:0]     o_packet_word,
    output logic                            o_last_word,
    output logic                            o_put_status,
    output logic                            o_stream_out
);

    logic [rtpq_pkg::WORD_W-1:0] r_mem [rtpq_pkg::STORE_WORDS];
    logic [rtpq_pkg::WORD_W-1:0] r_rd_data;

    logic [rtpq_pkg::SLOT_W-1:0] r_vid_rd, r_vid_wr, r_aud_rd, r_aud_wr;
    logic [rtpq_pkg::IDX_W-1:0]  r_fill [2];
    logic                        r_drop [2];
    logic                        r_send_q;

    logic [rtpq_pkg::WORD_W-1:0] r_ssrc;
    logic [rtpq_pkg::PT_W-1:0]   r_pt;
    logic [rtpq_pkg::SEQ_W-1:0]  r_seq;

    logic                        r_out_valid;
    logic                        r_kind, r_last, r_status, r_stream;
    logic [rtpq_pkg::WORD_W-1:0] r_word;

    // put side
    logic [rtpq_pkg::SLOT_W-1:0] in_rd, in_wr;
    logic [rtpq_pkg::IDX_W-1:0]  put_idx;
    logic                        put_drop, put_last, mem_we;
    logic [rtpq_pkg::ADDR_W-1:0] wr_addr;

    // send side
    logic [rtpq_pkg::SLOT_W-1:0] send_rd;
    logic                        rd_en, send_done;
    logic [rtpq_pkg::ADDR_W-1:0] rd_addr;
    logic [rtpq_pkg::CNT_W-1:0]  rd_word;
    logic [rtpq_pkg::WORD_W-1:0] send_word;

    always_comb begin
        in_rd   = i_in_stream ? r_aud_rd : r_vid_rd;
        in_wr   = i_in_stream ? r_aud_wr : r_vid_wr;
        put_idx = r_fill[i_in_stream];
        // fullness is sampled at the first word and held for the rest of the packet
        put_drop = (put_idx == '0) ? (in_rd == rtpq_pkg::next_slot(in_wr))
                                   : r_drop[i_in_stream];
        put_last = (put_idx == rtpq_pkg::LAST_IDX);
        mem_we   = i_cmd.put && !put_drop;
        wr_addr  = rtpq_pkg::store_addr(i_in_stream, in_wr, put_idx);

        o_status.sel_empty = (in_rd == in_wr);
        o_status.out_free  = !r_out_valid || i_out_ready;

        send_rd   = r_send_q ? r_aud_rd : r_vid_rd;
        rd_en     = i_cmd.send_adv && (i_cmd.word_cnt >= rtpq_pkg::RD_FIRST)
                    && (i_cmd.word_cnt <= rtpq_pkg::RD_LAST);
        rd_word   = i_cmd.word_cnt - rtpq_pkg::RD_FIRST;
        rd_addr   = rtpq_pkg::store_addr(r_send_q, send_rd, rd_word[rtpq_pkg::IDX_W-1:0]);
        send_done = i_cmd.send_adv && (i_cmd.word_cnt == rtpq_pkg::LAST_CNT);

        case (i_cmd.word_cnt)
            rtpq_pkg::CNT_HDR0: send_word = {rtpq_pkg::RTP_VERSION_BYTE, 1'b0, r_pt, r_seq};
            rtpq_pkg::CNT_HDR1: send_word = '0;  // timestamp
            rtpq_pkg::CNT_HDR2: send_word = r_ssrc;
            default:            send_word = r_rd_data;
        endcase
    end

    // packet store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // queue pointers and fill state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vid_rd <= '0;
            r_vid_wr <= '0;
            r_aud_rd <= '0;
            r_aud_wr <= '0;
            r_fill[0] <= '0;
            r_fill[1] <= '0;
            r_drop[0] <= 1'b0;
            r_drop[1] <= 1'b0;
            r_send_q <= 1'b0;
        end else begin
            if (i_cmd.put) begin
                if (put_last) begin
                    r_fill[i_in_stream] <= '0;
                    r_drop[i_in_stream] <= 1'b0;
                    if (!put_drop) begin
                        if (i_in_stream) begin
                            r_aud_wr <= rtpq_pkg::next_slot(r_aud_wr);
                        end else begin
                            r_vid_wr <= rtpq_pkg::next_slot(r_vid_wr);
                        end
                    end
                end else begin
                    r_fill[i_in_stream] <= put_idx + rtpq_pkg::IDX_W'(1);
                    r_drop[i_in_stream] <= put_drop;
                end
            end
            if (i_cmd.send_start) begin
                r_send_q <= i_in_stream;
            end
            if (send_done) begin
                if (r_send_q) begin
                    r_aud_rd <= rtpq_pkg::next_slot(r_aud_rd);
                end else begin
                    r_vid_rd <= rtpq_pkg::next_slot(r_vid_rd);
                end
            end
        end
    end

    // configuration and sequence counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ssrc <= '0;
            r_pt   <= rtpq_pkg::PT_RESET;
            r_seq  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rtpq_pkg::CFG_SSRC:      r_ssrc <= i_cfg_data;
                    rtpq_pkg::CFG_START_SEQ: r_seq  <= i_cfg_data[rtpq_pkg::SEQ_W-1:0];
                    rtpq_pkg::CFG_PT:        r_pt   <= i_cfg_data[rtpq_pkg::PT_W-1:0];
                    default: ;
                endcase
            end else if (send_done) begin
                r_seq <= r_seq + rtpq_pkg::SEQ_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.put && put_last) begin
            r_out_valid <= 1'b1;
        end else if (i_cmd.send_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put && put_last) begin
            r_kind   <= rtpq_pkg::KIND_STATUS;
            r_word   <= '0;
            r_last   <= 1'b0;
            r_status <= put_drop;
            r_stream <= i_in_stream;
        end else if (i_cmd.send_adv) begin
            r_kind   <= rtpq_pkg::KIND_WORD;
            r_word   <= send_word;
            r_last   <= (i_cmd.word_cnt == rtpq_pkg::LAST_CNT);
            r_status <= 1'b0;
            r_stream <= r_send_q;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_item_kind   = r_kind;
    assign o_packet_word = r_word;
    assign o_last_word   = r_last;
    assign o_put_status  = r_status;
    assign o_stream_out  = r_stream;

endmodule

@@ rtl/core/rtp_ts_packetizer_queue.sv @@
// Top level: two-queue RTP packetizer for 188-byte transport packets (video, audio).
// Put: one payload word per cycle while the sequencer is idle and the output register
//   has room; the status item of a packet appears at the output the cycle after its
//   47th word is accepted. Send: 50 words (3 header, 47 payload) at one per cycle
//   while the sink is ready; no new item is taken until the sequence ends (sequencer).
// Reset (synchronous, active low) empties both queues; the store needs no clearing pass.
`timescale 1ns / 1ps
module rtp_ts_packetizer_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rtpq_in_if.sink                         i_in,
    rtpq_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [rtpq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rtpq_pkg::WORD_W-1:0]     i_cfg_data
);

    // command/status pair between sequencer and datapath
    rtpq_pkg::t_dp_cmd    cmd;
    rtpq_pkg::t_dp_status status;
    logic                 in_ready;

    // controller: accepts items while idle and the output register has room;
    // a send on a non-empty queue starts the 50-word header+payload sequence
    rtpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.operation),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // datapath: packet store (2 x QUEUE_SLOTS x 47 words), ring pointers,
    // drop flags, config registers, shared sequence counter, output register
    rtpq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_stream   (i_in.stream_sel),
        .i_in_word     (i_in.payload_word),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_item_kind   (o_out.item_kind),
        .o_packet_word (o_out.packet_word),
        .o_last_word   (o_out.last_word),
        .o_put_status  (o_out.put_status),
        .o_stream_out  (o_out.stream_out)
    );

endmodule
